FILE: rtl/core/imexp_pkg.sv
// Shared beat types and field widths for the iterated modular exponentiation core.
`default_nettype none
package imexp_pkg;

  localparam int FIELD_W  = 32;
  localparam int HEIGHT_W = 7;

  typedef struct packed {
    logic [FIELD_W-1:0]  base_value;
    logic [HEIGHT_W-1:0] tower_height;
    logic [FIELD_W-1:0]  modulus;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] residue;
    logic               bad_modulus;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/imexp_modmul.sv
// Bit-serial interleaved modular multiplier: p = (x * y) mod m, one bit of x per cycle.
`default_nettype none
module imexp_modmul #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         go,
  input  wire logic [W-1:0] x,
  input  wire logic [W-1:0] y,
  input  wire logic [W-1:0] m,
  output logic              busy,
  output logic              done,
  output logic [W-1:0]      p
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  xs;
  logic [W-1:0]  ys;
  logic [W-1:0]  ms;
  logic [W-1:0]  r;
  logic [W-1:0]  r_next;
  logic [CW-1:0] cnt;
  logic [W-1:0]  yadd;
  logic [W+1:0]  t;
  logic [W+1:0]  m1;
  logic [W+1:0]  m2;

  always_comb begin
    yadd = xs[W-1] ? ys : '0;
    t    = {1'b0, r, 1'b0} + {2'b00, yadd};
    m1   = {2'b00, ms};
    m2   = {1'b0, ms, 1'b0};
    if (t >= m2) begin
      r_next = W'(t - m2);
    end else if (t >= m1) begin
      r_next = W'(t - m1);
    end else begin
      r_next = W'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        xs   <= x;
        ys   <= y;
        ms   <= m;
        r    <= '0;
        cnt  <= CW'(W);
        busy <= 1'b1;
      end else if (busy) begin
        r   <= r_next;
        xs  <= xs << 1;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign p = r;

endmodule
`default_nettype wire

FILE: rtl/core/iterated_modular_exponentiation_core.sv
// Top level: iterated modular exponentiation with bit-serial modular multipliers.
// An item is taken when start is high and busy is low; its result shows on
// result for exactly one cycle with done high and cannot be held off. A zero
// modulus or a zero height gives its result in the cycle after the item is
// taken, with busy staying low. Otherwise the base is first reduced modulo the
// modulus, then each level steps through the exponent bits up to the highest set
// bit of the running value; the multiply and the square of one bit run in two
// serial multipliers side by side.
`default_nettype none
module iterated_modular_exponentiation_core #(
  parameter int MAX_HEIGHT    = 64,
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire imexp_pkg::in_item_t operands,
  output logic                    done,
  output imexp_pkg::result_t      result
);

  localparam int W  = OPERAND_WIDTH;
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_LVL,
    ST_BIT,
    ST_WAIT
  } state_t;

  state_t state;

  logic [W-1:0]  mod;
  logic [W-1:0]  bred;
  logic [W-1:0]  acc;
  logic [W-1:0]  sq;
  logic [W-1:0]  e;
  logic [HW-1:0] height_lim;
  logic [HW-1:0] level;
  logic [HW-1:0] level_next;
  logic [HW-1:0] hsat;
  logic [W-1:0]  in_base;
  logic [W-1:0]  in_mod;

  logic          a_go;
  logic [W-1:0]  a_x;
  logic [W-1:0]  a_y;
  logic          a_busy;
  logic          a_done;
  logic [W-1:0]  a_p;
  logic          b_go;
  logic [W-1:0]  b_x;
  logic          b_busy;
  logic          b_done;
  logic [W-1:0]  b_p;

  assign in_base    = operands.base_value[W-1:0];
  assign in_mod     = operands.modulus[W-1:0];
  assign level_next = level + 1'b1;
  assign busy       = (state != ST_IDLE);

  always_comb begin
    if (32'(operands.tower_height) > 32'(MAX_HEIGHT)) begin
      hsat = HW'(MAX_HEIGHT);
    end else begin
      hsat = HW'(operands.tower_height);
    end
  end

  imexp_modmul #(.W(W)) u_mul_acc (
    .clk  (clk),
    .rst  (rst),
    .go   (a_go),
    .x    (a_x),
    .y    (a_y),
    .m    (mod),
    .busy (a_busy),
    .done (a_done),
    .p    (a_p)
  );

  imexp_modmul #(.W(W)) u_mul_sq (
    .clk  (clk),
    .rst  (rst),
    .go   (b_go),
    .x    (b_x),
    .y    (b_x),
    .m    (mod),
    .busy (b_busy),
    .done (b_done),
    .p    (b_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      a_go  <= 1'b0;
      b_go  <= 1'b0;
    end else begin
      done <= 1'b0;
      a_go <= 1'b0;
      b_go <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            mod        <= in_mod;
            height_lim <= hsat;
            if (in_mod == '0) begin
              result.residue     <= '0;
              result.bad_modulus <= 1'b1;
              done               <= 1'b1;
            end else if (hsat == '0) begin
              result.residue     <= imexp_pkg::FIELD_W'(1);
              result.bad_modulus <= 1'b0;
              done               <= 1'b1;
            end else begin
              a_go  <= 1'b1;
              a_x   <= in_base;
              a_y   <= W'(1);
              state <= ST_RED;
            end
          end
        end
        ST_RED: begin
          if (a_done) begin
            bred  <= a_p;
            e     <= W'(1);
            level <= '0;
            state <= ST_LVL;
          end
        end
        ST_LVL: begin
          acc   <= W'(1);
          sq    <= bred;
          state <= ST_BIT;
        end
        ST_BIT: begin
          if (e == '0) begin
            if (level_next == height_lim) begin
              result.residue     <= imexp_pkg::FIELD_W'(acc);
              result.bad_modulus <= 1'b0;
              done               <= 1'b1;
              state              <= ST_IDLE;
            end else begin
              e     <= acc;
              level <= level_next;
              state <= ST_LVL;
            end
          end else begin
            a_go  <= e[0];
            a_x   <= acc;
            a_y   <= sq;
            b_go  <= 1'b1;
            b_x   <= sq;
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (b_done) begin
            if (e[0]) begin
              acc <= a_p;
            end
            sq    <= b_p;
            e     <= e >> 1;
            state <= ST_BIT;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_wait_sq: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT) |-> (b_go || b_busy || b_done))
    else $error("square unit idle while a bit is in progress");

  a_acc_pair: assert property (@(posedge clk) disable iff (rst)
    a_busy |-> (b_busy || state == ST_RED))
    else $error("multiply unit running without the square unit");

  a_reduced: assert property (@(posedge clk) disable iff (rst)
    (a_done || b_done) |-> ((!a_done || (a_p < mod)) && (!b_done || (b_p < mod))))
    else $error("multiplier result not reduced");

  a_mod_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (mod != '0))
    else $error("working on a zero modulus");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.bad_modulus) |-> (result.residue == '0))
    else $error("zero modulus beat with nonzero residue");

endmodule
`default_nettype wire
